@@ rtl/mwalu_pkg.sv @@
// ----------------------------------------------------------------------------
// mwalu_pkg
// Shared codes, types and helpers of the multi-width integer alu.
// ----------------------------------------------------------------------------
`default_nettype none

package mwalu_pkg;

  localparam int DEF_MAX_WIDTH = 64;
  localparam int DATA_W        = 64;

  typedef enum logic [3:0] {
    FN_ADD  = 4'd0,
    FN_SUB  = 4'd1,
    FN_MUL  = 4'd2,
    FN_SHL  = 4'd3,
    FN_ASHR = 4'd4,
    FN_LSHR = 4'd5,
    FN_SDIV = 4'd6,
    FN_UDIV = 4'd7,
    FN_SREM = 4'd8,
    FN_UREM = 4'd9,
    FN_CMP  = 4'd10,
    FN_UMIN = 4'd11,
    FN_SMIN = 4'd12,
    FN_UMAX = 4'd13,
    FN_SMAX = 4'd14,
    FN_ABS  = 4'd15
  } func_t;

  localparam logic [2:0] WS_1  = 3'd0;
  localparam logic [2:0] WS_8  = 3'd1;
  localparam logic [2:0] WS_16 = 3'd2;
  localparam logic [2:0] WS_32 = 3'd3;
  localparam logic [2:0] WS_64 = 3'd4;

  // control that rides along with a request through the chain
  typedef struct packed {
    logic       vld;
    func_t      func;
    logic [2:0] wsel;
    logic       ok;
    logic       neg;
  } ctl_t;

  // width in bits, zero for an unused code
  function automatic logic [6:0] width_bits(input logic [2:0] sel);
    logic [6:0] w;
    case (sel)
      WS_1:    w = 7'd1;
      WS_8:    w = 7'd8;
      WS_16:   w = 7'd16;
      WS_32:   w = 7'd32;
      WS_64:   w = 7'd64;
      default: w = 7'd0;
    endcase
    return w;
  endfunction

  function automatic logic is_div(input func_t f);
    return (f == FN_SDIV) || (f == FN_UDIV) || (f == FN_SREM) || (f == FN_UREM);
  endfunction

endpackage

`default_nettype wire

@@ rtl/mwalu_prep.sv @@
// ----------------------------------------------------------------------------
// mwalu_prep
// Input stage: masks operands, computes the results that need no chain and
// loads the chain for multiply and divide.
// ----------------------------------------------------------------------------
`default_nettype none

module mwalu_prep #(
  parameter int MW = mwalu_pkg::DEF_MAX_WIDTH
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire  [3:0]                   func,
  input  wire  [2:0]                   width_sel,
  input  wire  [mwalu_pkg::DATA_W-1:0] operand_a,
  input  wire  [mwalu_pkg::DATA_W-1:0] operand_b,
  input  wire                          no_signed_wrap,
  input  wire                          no_unsigned_wrap,
  input  wire  [4:0]                   cmp_mask,
  output mwalu_pkg::ctl_t              ctl,
  output logic [MW-1:0]                x,
  output logic [MW-1:0]                y,
  output logic [MW-1:0]                acc,
  output logic [MW-1:0]                res
);
  import mwalu_pkg::*;

  func_t       fn;
  logic [6:0]  w;
  logic        w_ok;
  logic [MW-1:0] mask, sbm, u, v, r, ma, mb;
  logic        su, sv, ok, neg, big, pm, mp, c;
  ctl_t        ctl_next;
  logic [MW-1:0] x_next, y_next;

  always_comb begin
    fn   = func_t'(func);
    w    = width_bits(width_sel);
    w_ok = (w != 7'd0) && (int'(w) <= MW);
    for (int i = 0; i < MW; i++) begin
      mask[i] = 7'(i) < w;
    end
    sbm = mask & ~(mask >> 1);
    u   = operand_a[MW-1:0] & mask;
    v   = operand_b[MW-1:0] & mask;
    su  = |(u & sbm);
    sv  = |(v & sbm);
    big = v >= MW'(w);
    ma  = su ? ((~u + 1'b1) & mask) : u;
    mb  = sv ? ((~v + 1'b1) & mask) : v;
    pm  = !su && sv;
    mp  = su && !sv;
    c   = (cmp_mask[4] && pm) || (cmp_mask[3] && mp) || (cmp_mask[2] && u > v && !mp) ||
          (cmp_mask[1] && u < v && !pm) || (cmp_mask[0] && u == v);
    ok     = w_ok;
    neg    = 1'b0;
    r      = '0;
    x_next = u;
    y_next = v;
    case (fn)
      FN_ADD: begin
        r = (u + v) & mask;
        if (no_unsigned_wrap && r < u) ok = 1'b0;
      end
      FN_SUB: r = (u - v) & mask;
      FN_MUL: r = '0;
      FN_SHL: begin
        r = (u << v) & mask;
        if (big) ok = 1'b0;
        if (no_unsigned_wrap && r < u) ok = 1'b0;
        if (no_signed_wrap && (|(r & sbm) != su)) ok = 1'b0;
      end
      FN_ASHR: begin
        r = u >> v;
        if (su) r = r | (mask & ~(mask >> v));
        if (big) ok = 1'b0;
      end
      FN_LSHR: begin
        r = u >> v;
        if (big) ok = 1'b0;
      end
      FN_SDIV: begin
        x_next = ma;
        y_next = mb;
        neg    = su != sv;
        if (v == '0) ok = 1'b0;
      end
      FN_SREM: begin
        x_next = ma;
        y_next = mb;
        neg    = su;
        if (v == '0) ok = 1'b0;
      end
      FN_UDIV, FN_UREM: begin
        if (v == '0) ok = 1'b0;
      end
      FN_CMP:  r = MW'(c);
      FN_UMIN: r = (u < v) ? u : v;
      FN_SMIN: r = ((u ^ sbm) < (v ^ sbm)) ? u : v;
      FN_UMAX: r = (u > v) ? u : v;
      FN_SMAX: r = ((u ^ sbm) > (v ^ sbm)) ? u : v;
      default: r = ma;
    endcase
    ctl_next.vld  = start;
    ctl_next.func = fn;
    ctl_next.wsel = width_sel;
    ctl_next.ok   = ok;
    ctl_next.neg  = neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.vld <= 1'b0;
    end else begin
      ctl.vld <= ctl_next.vld;
    end
    ctl.func <= ctl_next.func;
    ctl.wsel <= ctl_next.wsel;
    ctl.ok   <= ctl_next.ok;
    ctl.neg  <= ctl_next.neg;
    x        <= x_next;
    y        <= y_next;
    acc      <= '0;
    res      <= r;
  end

endmodule

`default_nettype wire

@@ rtl/mwalu_cell.sv @@
// ----------------------------------------------------------------------------
// mwalu_cell
// One chain cell: a shift-add multiply step or a restoring divide step.
// ----------------------------------------------------------------------------
`default_nettype none

module mwalu_cell #(
  parameter int MW = mwalu_pkg::DEF_MAX_WIDTH
) (
  input  wire                  clk,
  input  wire                  rst,
  input  mwalu_pkg::ctl_t      ctl_in,
  input  wire  [MW-1:0]        x_in,
  input  wire  [MW-1:0]        y_in,
  input  wire  [MW-1:0]        acc_in,
  input  wire  [MW-1:0]        res_in,
  output mwalu_pkg::ctl_t      ctl,
  output logic [MW-1:0]        x,
  output logic [MW-1:0]        y,
  output logic [MW-1:0]        acc
  ,output logic [MW-1:0]       res
);
  import mwalu_pkg::*;

  logic [MW:0]   t, diff;
  logic          ge;
  logic [MW-1:0] x_next, y_next, acc_next;

  always_comb begin
    t    = {acc_in, x_in[MW-1]};
    diff = t - {1'b0, y_in};
    ge   = t >= {1'b0, y_in};
    if (is_div(ctl_in.func)) begin
      // quotient bits shift in from the right as dividend bits leave
      acc_next = ge ? diff[MW-1:0] : t[MW-1:0];
      x_next   = {x_in[MW-2:0], ge};
      y_next   = y_in;
    end else begin
      acc_next = acc_in + (y_in[0] ? x_in : '0);
      x_next   = x_in << 1;
      y_next   = y_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.vld <= 1'b0;
    end else begin
      ctl.vld <= ctl_in.vld;
    end
    ctl.func <= ctl_in.func;
    ctl.wsel <= ctl_in.wsel;
    ctl.ok   <= ctl_in.ok;
    ctl.neg  <= ctl_in.neg;
    x        <= x_next;
    y        <= y_next;
    acc      <= acc_next;
    res      <= res_in;
  end

`ifndef NO_ASSERTIONS
  // partial remainder always stays below the divisor
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    ctl.vld && ctl.ok && is_div(ctl.func) |-> acc < y)
    else $error("remainder not below divisor");
`endif

endmodule

`default_nettype wire

@@ rtl/mwalu_post.sv @@
// ----------------------------------------------------------------------------
// mwalu_post
// Output stage: picks the result, fixes signs, masks to width, registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mwalu_post #(
  parameter int MW = mwalu_pkg::DEF_MAX_WIDTH
) (
  input  wire                          clk,
  input  wire                          rst,
  input  mwalu_pkg::ctl_t              ctl_in,
  input  wire  [MW-1:0]                x_in,
  input  wire  [MW-1:0]                acc_in,
  input  wire  [MW-1:0]                res_in,
  output logic                         done,
  output logic [mwalu_pkg::DATA_W-1:0] result,
  output logic                         defined
);
  import mwalu_pkg::*;

  logic [MW-1:0]     val;
  logic [6:0]        w;
  logic [DATA_W-1:0] mask64, result_next;

  always_comb begin
    case (ctl_in.func)
      FN_MUL:  val = acc_in;
      FN_UDIV: val = x_in;
      FN_UREM: val = acc_in;
      FN_SDIV: val = ctl_in.neg ? (~x_in + 1'b1) : x_in;
      FN_SREM: val = ctl_in.neg ? (~acc_in + 1'b1) : acc_in;
      default: val = res_in;
    endcase
    w = width_bits(ctl_in.wsel);
    for (int i = 0; i < DATA_W; i++) begin
      mask64[i] = 7'(i) < w;
    end
    result_next = ctl_in.ok ? (DATA_W'(val) & mask64) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_in.vld;
    end
    result  <= result_next;
    defined <= ctl_in.ok;
  end

endmodule

`default_nettype wire

@@ rtl/multi_width_integer_alu.sv @@
// ----------------------------------------------------------------------------
// multi_width_integer_alu
// Integer alu at 1, 8, 16, 32 or 64 bits with undefined-result flagging.
// ----------------------------------------------------------------------------
// channel   ports                                       handshake
// request   func width_sel operand_a operand_b          start (busy is 0)
//           no_signed_wrap no_unsigned_wrap cmp_mask
// result    result defined                              done, one cycle
//
// one request per cycle; each result passes the input register, the chain of
// MAX_WIDTH cells with one multiply or divide step per cell, and the output
// register.
// rst clears all valid bits in the chain; requests in flight are dropped.
// busy stays low and the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_width_integer_alu #(
  parameter int MAX_WIDTH = mwalu_pkg::DEF_MAX_WIDTH
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire  [3:0]                   func,
  input  wire  [2:0]                   width_sel,
  input  wire  [mwalu_pkg::DATA_W-1:0] operand_a,
  input  wire  [mwalu_pkg::DATA_W-1:0] operand_b,
  input  wire                          no_signed_wrap,
  input  wire                          no_unsigned_wrap,
  input  wire  [4:0]                   cmp_mask,
  output logic                         done,
  output logic [mwalu_pkg::DATA_W-1:0] result,
  output logic                         defined
);
  import mwalu_pkg::*;

  localparam int LAT = MAX_WIDTH + 2;

  ctl_t                 ctl [MAX_WIDTH+1];
  logic [MAX_WIDTH-1:0] xs  [MAX_WIDTH+1];
  logic [MAX_WIDTH-1:0] ys  [MAX_WIDTH+1];
  logic [MAX_WIDTH-1:0] accs[MAX_WIDTH+1];
  logic [MAX_WIDTH-1:0] ress[MAX_WIDTH+1];

  assign busy = 1'b0;

  mwalu_prep #(.MW(MAX_WIDTH)) u_prep (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .func             (func),
    .width_sel        (width_sel),
    .operand_a        (operand_a),
    .operand_b        (operand_b),
    .no_signed_wrap   (no_signed_wrap),
    .no_unsigned_wrap (no_unsigned_wrap),
    .cmp_mask         (cmp_mask),
    .ctl              (ctl[0]),
    .x                (xs[0]),
    .y                (ys[0]),
    .acc              (accs[0]),
    .res              (ress[0])
  );

  for (genvar g = 0; g < MAX_WIDTH; g++) begin : g_cell
    mwalu_cell #(.MW(MAX_WIDTH)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl_in (ctl[g]),
      .x_in   (xs[g]),
      .y_in   (ys[g]),
      .acc_in (accs[g]),
      .res_in (ress[g]),
      .ctl    (ctl[g+1]),
      .x      (xs[g+1]),
      .y      (ys[g+1]),
      .acc    (accs[g+1]),
      .res    (ress[g+1])
    );
  end

  mwalu_post #(.MW(MAX_WIDTH)) u_post (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl[MAX_WIDTH]),
    .x_in    (xs[MAX_WIDTH]),
    .acc_in  (accs[MAX_WIDTH]),
    .res_in  (ress[MAX_WIDTH]),
    .done    (done),
    .result  (result),
    .defined (defined)
  );

`ifndef NO_ASSERTIONS
  a_req_done: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(LAT) done)
    else $error("request produced no result");
  a_done_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without request");
  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    done && !defined |-> result == '0)
    else $error("undefined result not zero");
`endif

endmodule

`default_nettype wire

@@ bench/multi_width_integer_alu_tb.sv @@
// ----------------------------------------------------------------------------
// multi_width_integer_alu_tb
// Drives directed and random alu requests at every width, including the
// undefined width codes, and checks each result and defined flag against a
// predictor kept in the bench. The sender idles at random in 2 of 3 phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module multi_width_integer_alu_tb;
  import mwalu_pkg::*;

  localparam int LATENCY   = DEF_MAX_WIDTH + 2;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 1500;

  typedef struct {
    func_t       fn;
    logic [2:0]  wsel;
    logic [63:0] a;
    logic [63:0] b;
    logic        nsw;
    logic        nuw;
    logic [4:0]  cmask;
  } alu_req_t;

  typedef struct {
    logic [63:0] value;
    logic        valid;
  } alu_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  func = '0;
  logic [2:0]  width_sel = '0;
  logic [63:0] operand_a = '0;
  logic [63:0] operand_b = '0;
  logic        no_signed_wrap = 1'b0;
  logic        no_unsigned_wrap = 1'b0;
  logic [4:0]  cmp_mask = '0;
  logic        done;
  logic [63:0] result;
  logic        defined;

  alu_req_t pending_reqs[$];
  alu_res_t expected_results[$];
  int       send_idle_pct = 32;
  bit       hold_sender = 1'b0;
  bit       stim_done = 1'b0;
  int       errors = 0;
  int       idle_cycles = 0;

  // busy sampled at the edge that accepts the request
  alu_req_t cur_req;
  logic     busy_s = 1'b0;
  logic     acc_s = 1'b0;

  multi_width_integer_alu dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .width_sel(width_sel), .operand_a(operand_a), .operand_b(operand_b),
    .no_signed_wrap(no_signed_wrap), .no_unsigned_wrap(no_unsigned_wrap),
    .cmp_mask(cmp_mask), .done(done), .result(result), .defined(defined)
  );

  always #2 clk = ~clk;

  function automatic alu_res_t alu_predict(input alu_req_t q);
    alu_res_t   res;
    int         w;
    logic [63:0] mask, sb, u, v, r, ma, mb, qt;
    bit         ok, su, sv, pm, mp, c;
    res.value = '0;
    res.valid = 1'b0;
    case (q.wsel)
      WS_1:    w = 1;
      WS_8:    w = 8;
      WS_16:   w = 16;
      WS_32:   w = 32;
      WS_64:   w = 64;
      default: w = 0;
    endcase
    if (w == 0) return res;
    mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
    sb = 64'd1 << (w - 1);
    u = q.a & mask;
    v = q.b & mask;
    su = (u & sb) != 0;
    sv = (v & sb) != 0;
    ok = 1'b1;
    r = '0;
    case (q.fn)
      FN_ADD: begin
        r = (u + v) & mask;
        if (q.nuw && r < u) ok = 1'b0;
      end
      FN_SUB: r = (u - v) & mask;
      FN_MUL: r = (u * v) & mask;
      FN_SHL: begin
        if (v >= w) ok = 1'b0;
        else begin
          r = (u << v) & mask;
          if (q.nuw && r < u) ok = 1'b0;
          if (q.nsw && (((r & sb) != 0) != su)) ok = 1'b0;
        end
      end
      FN_ASHR: begin
        if (v >= w) ok = 1'b0;
        else begin
          r = u >> v;
          if (su) r |= mask & ~(mask >> v);
        end
      end
      FN_LSHR: begin
        if (v >= w) ok = 1'b0;
        else r = u >> v;
      end
      FN_SDIV, FN_SREM: begin
        if (v == 0) ok = 1'b0;
        else begin
          ma = su ? ((64'd0 - u) & mask) : u;
          mb = sv ? ((64'd0 - v) & mask) : v;
          if (q.fn == FN_SDIV) begin
            qt = ma / mb;
            r = ((su != sv) ? (64'd0 - qt) : qt) & mask;
          end else begin
            qt = ma % mb;
            r = (su ? (64'd0 - qt) : qt) & mask;
          end
        end
      end
      FN_UDIV: begin
        if (v == 0) ok = 1'b0;
        else r = u / v;
      end
      FN_UREM: begin
        if (v == 0) ok = 1'b0;
        else r = u % v;
      end
      FN_CMP: begin
        pm = !su && sv;
        mp = su && !sv;
        c = (q.cmask[4] && pm) || (q.cmask[3] && mp) || (q.cmask[2] && u > v && !mp)
            || (q.cmask[1] && u < v && !pm) || (q.cmask[0] && u == v);
        r = c ? 64'd1 : 64'd0;
      end
      FN_UMIN: r = (u < v) ? u : v;
      FN_SMIN: r = ((u ^ sb) < (v ^ sb)) ? u : v;
      FN_UMAX: r = (u > v) ? u : v;
      FN_SMAX: r = ((u ^ sb) > (v ^ sb)) ? u : v;
      default: r = su ? ((64'd0 - u) & mask) : u;
    endcase
    if (ok) begin
      res.value = r & mask;
      res.valid = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] x;
    x = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: x = '0;
      1: x = '1;
      2: x = 64'd1 << $urandom_range(0, 63);
      3: x = x & 64'h3f;
      default: ;
    endcase
    return x;
  endfunction

  function automatic alu_req_t make_req(input func_t fn, input logic [2:0] ws,
                                        input logic [63:0] a, input logic [63:0] b,
                                        input logic nsw, input logic nuw,
                                        input logic [4:0] cm);
    alu_req_t q;
    q.fn = fn; q.wsel = ws; q.a = a; q.b = b;
    q.nsw = nsw; q.nuw = nuw; q.cmask = cm;
    return q;
  endfunction

  function automatic alu_req_t random_req();
    alu_req_t q;
    q.fn = func_t'($urandom_range(0, 15));
    // mostly legal widths, a few unused codes
    q.wsel = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
    q.a = rand64();
    q.b = rand64();
    if (q.fn inside {FN_SHL, FN_ASHR, FN_LSHR} && $urandom_range(0, 3) != 0)
      q.b = {$urandom, $urandom} & ~64'h3f | 64'($urandom_range(0, 63));
    q.nsw = 1'($urandom_range(0, 1));
    q.nuw = 1'($urandom_range(0, 1));
    q.cmask = 5'($urandom_range(0, 31));
    return q;
  endfunction

  // driver
  always @(negedge clk) begin
    alu_req_t q;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy_s) begin
        void'(pending_reqs.pop_front());
        expected_results.push_back(alu_predict(cur_req));
      end
      if (pending_reqs.size() != 0 && !hold_sender &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        q = pending_reqs[0];
        cur_req <= q;
        start <= 1'b1;
        func <= q.fn;
        width_sel <= q.wsel;
        operand_a <= q.a;
        operand_b <= q.b;
        no_signed_wrap <= q.nsw;
        no_unsigned_wrap <= q.nuw;
        cmp_mask <= q.cmask;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    busy_s <= busy;
    acc_s  <= start && !busy && !rst;
  end

  // monitor
  always @(posedge clk) begin
    alu_res_t e;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: result=%h defined=%b", result, defined);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (result !== e.value) begin
          $error("result: expected %h, actual %h", e.value, result);
          errors++;
        end
        if (defined !== e.valid) begin
          $error("defined: expected %b, actual %b", e.valid, defined);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || done || rst) idle_cycles <= 0;
    else if (pending_reqs.size() != 0 || expected_results.size() != 0 || acc_s)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || start || acc_s) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    int cnt;
    logic [63:0] smin64;
    smin64 = 64'h8000_0000_0000_0000;
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: every operation at the extremes and the special cases
    pending_reqs.push_back(make_req(FN_ADD, WS_64, '1, 64'd1, 1'b0, 1'b1, '0));
    pending_reqs.push_back(make_req(FN_ADD, WS_8, 64'hff, 64'd1, 1'b0, 1'b0, '0));
    pending_reqs.push_back(make_req(FN_SUB, WS_64, '0, 64'd1, 1'b1, 1'b1, '0));
    pending_reqs.push_back(make_req(FN_MUL, WS_64, '1, '1, 1'b0, 1'b0, '0));
    pending_reqs.push_back(make_req(FN_SHL, WS_64, 64'd1, 64'd63, 1'b1, 1'b0, '0));
    pending_reqs.push_back(make_req(FN_SHL, WS_8, 64'h81, 64'd1, 1'b0, 1'b1, '0));
    pending_reqs.push_back(make_req(FN_SHL, WS_16, 64'd1, 64'd16, 1'b0, 1'b0, '0));
    pending_reqs.push_back(make_req(FN_ASHR, WS_32, 64'h8000_0000, 64'd31, 1'b0, 1'b0, '0));
    pending_reqs.push_back(make_req(FN_LSHR, WS_1, 64'd1, 64'd1, 1'b0, 1'b0, '0));
    pending_reqs.push_back(make_req(FN_SDIV, WS_64, smin64, '1, 1'b0, 1'b0, '0));
    pending_reqs.push_back(make_req(FN_SREM, WS_64, smin64, '1, 1'b0, 1'b0, '0));
    pending_reqs.push_back(make_req(FN_SDIV, WS_8, 64'hf9, 64'd2, 1'b0, 1'b0, '0));
    pending_reqs.push_back(make_req(FN_SREM, WS_8, 64'hf9, 64'd2, 1'b0, 1'b0, '0));
    pending_reqs.push_back(make_req(FN_UDIV, WS_32, 64'd5, 64'd0, 1'b0, 1'b0, '0));
    pending_reqs.push_back(make_req(FN_UREM, WS_64, '1, 64'd7, 1'b0, 1'b0, '0));
    pending_reqs.push_back(make_req(FN_CMP, WS_8, 64'h05, 64'h85, 1'b0, 1'b0, 5'b10000));
    pending_reqs.push_back(make_req(FN_CMP, WS_8, 64'h85, 64'h05, 1'b0, 1'b0, 5'b01000));
    pending_reqs.push_back(make_req(FN_CMP, WS_64, '1, '1, 1'b0, 1'b0, 5'b00001));
    pending_reqs.push_back(make_req(FN_UMIN, WS_16, 64'hffff, 64'd1, 1'b0, 1'b0, '0));
    pending_reqs.push_back(make_req(FN_SMIN, WS_16, 64'hffff, 64'd1, 1'b0, 1'b0, '0));
    pending_reqs.push_back(make_req(FN_UMAX, WS_1, 64'd0, 64'd1, 1'b0, 1'b0, '0));
    pending_reqs.push_back(make_req(FN_SMAX, WS_1, 64'd0, 64'd1, 1'b0, 1'b0, '0));
    pending_reqs.push_back(make_req(FN_ABS, WS_64, smin64, '1, 1'b0, 1'b0, '0));
    pending_reqs.push_back(make_req(FN_ABS, 3'd7, '1, '1, 1'b1, 1'b1, '1));
    pending_reqs.push_back(make_req(FN_ADD, 3'd5, '1, '1, 1'b0, 1'b0, '0));

    // pause until every result has come back
    wait_drained();
    hold_sender = 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 61 : 0;
      cnt = (phase == 2) ? N_RANDOM - 2 * (N_RANDOM / 3) : N_RANDOM / 3;
      for (int i = 0; i < cnt; i++) pending_reqs.push_back(random_req());
      wait_drained();
    end
    send_idle_pct = 0;
    repeat (LATENCY + 8) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
